FILE: sv/xoshiro128pp_byte_generator_top_macros.svh
// Assertion macros for the xoshiro128++ byte generator.
// Used by the top level only; needs nothing else.
`ifndef XOSHIRO128PP_BYTE_GENERATOR_TOP_MACROS_SVH
`define XOSHIRO128PP_BYTE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define XPBG_ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("xpbg: same-cycle check failed");

// Next-cycle implication, ignored while in reset
`define XPBG_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("xpbg: next-cycle check failed");

`endif

FILE: sv/xpbg_pkg.sv
// Shared types and constants of the xoshiro128++ byte generator.
// No dependencies; imported by every module of the block.
package xpbg_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;

    // Largest request; larger counts saturate to this
    localparam logic [COUNT_W-1:0] MAX_BYTES = 7'd64;

    // Command codes on the input channel
    localparam logic CMD_ENTROPY = 1'b0;
    localparam logic CMD_BYTES   = 1'b1;

    // Seed words loaded at reset
    localparam logic [WORD_W-1:0] SEED0 = 32'h0E466F34;
    localparam logic [WORD_W-1:0] SEED1 = 32'hA2EA3931;
    localparam logic [WORD_W-1:0] SEED2 = 32'hBBC1951E;
    localparam logic [WORD_W-1:0] SEED3 = 32'h475D083D;

    // Generator shift and rotate amounts
    localparam int ROT_OUT   = 7;
    localparam int SHIFT_T   = 9;
    localparam int ROT_STATE = 11;

    typedef enum logic {
        OP_ENTROPY = 1'b0,
        OP_BYTES   = 1'b1
    } op_t;

    // One classified command, as held in the queue
    typedef struct packed {
        op_t                 kind;
        logic [WORD_W-1:0]   entropy;
        logic [COUNT_W-1:0]  count;
    } queue_entry_t;

    // Rotate left by a constant amount between 1 and 31
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input int n);
        rotl32 = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

FILE: sv/xpbg_queue.sv
// Short command queue between the front and back of the byte generator.
// Depends on xpbg_pkg for the entry type.
module xpbg_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  xpbg_pkg::queue_entry_t wr_entry,
    output logic                  wr_ready,
    input  logic                  pop,
    output xpbg_pkg::queue_entry_t rd_entry,
    output logic                  rd_valid
);
    import xpbg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic                   push_ok, pop_ok;

    assign wr_ready = (fill_reg != CNT_W'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign push_ok  = push && wr_ready;
    assign pop_ok   = pop && rd_valid;
    assign rd_entry = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push_ok && !pop_ok)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

FILE: sv/xpbg_front.sv
// Front end of the byte generator: takes input beats, classifies them,
// saturates the byte count and drops empty requests. Depends on xpbg_pkg.
module xpbg_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [xpbg_pkg::WORD_W-1:0]          entropy,
    input  logic [xpbg_pkg::COUNT_W-1:0]         byte_count,
    output logic                                 push,
    output xpbg_pkg::queue_entry_t               entry,
    input  logic                                 wr_ready
);
    import xpbg_pkg::*;

    logic          hold_valid_reg, hold_valid_next;
    queue_entry_t  hold_entry_reg;
    queue_entry_t  classified;
    logic          accept;
    logic          keep;

    // Stall only while the held beat cannot move into the queue
    assign in_stall = hold_valid_reg && !wr_ready;
    assign accept   = in_valid && !in_stall;
    assign push     = hold_valid_reg;
    assign entry    = hold_entry_reg;

    // Classify the beat and clamp its count
    always_comb
    begin
        classified.kind    = (cmd == CMD_BYTES) ? OP_BYTES : OP_ENTROPY;
        classified.entropy = entropy;
        classified.count   = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
        keep               = (cmd == CMD_ENTROPY) || (byte_count != '0);
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        priority if (accept)
        begin
            hold_valid_next = keep;
        end
        else if (wr_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the classified beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_entry_reg <= classified;
        end
    end

endmodule

FILE: sv/xpbg_back.sv
// Back end of the byte generator: holds the xoshiro128++ state, applies
// entropy and streams request bytes through an output register. Depends on xpbg_pkg.
module xpbg_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  xpbg_pkg::queue_entry_t       rd_entry,
    input  logic                         rd_valid,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [xpbg_pkg::BYTE_W-1:0]  rand_byte,
    output logic                         last_byte
);
    import xpbg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [WORD_W-1:0]     st_reg [4];
    logic [WORD_W-1:0]     st_next [4];
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  load_out;
    logic [WORD_W-1:0]     drawn;
    logic [WORD_W-1:0]     mixed;
    logic [WORD_W-1:0]     t_word, s2_x, s3_x, s1_x, s0_x;

    assign out_valid = out_valid_reg;
    assign rand_byte = byte_reg;
    assign last_byte = last_reg;
    assign load_out  = !out_valid_reg || !out_stall;
    assign mixed     = st_reg[0] ^ rd_entry.entropy;

    // One generator step on the current state
    always_comb
    begin
        drawn  = rotl32(st_reg[0] + st_reg[3], ROT_OUT) + st_reg[0];
        t_word = st_reg[1] << SHIFT_T;
        s2_x   = st_reg[2] ^ st_reg[0];
        s3_x   = st_reg[3] ^ st_reg[1];
        s1_x   = st_reg[1] ^ s2_x;
        s0_x   = st_reg[0] ^ s3_x;
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        word_next      = word_reg;
        left_next      = left_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the next command from the queue
                if (rd_valid)
                begin
                    pop = 1'b1;
                    if (rd_entry.kind == OP_ENTROPY)
                    begin
                        if (mixed != '0)
                        begin
                            st_next[0] = mixed;
                        end
                    end
                    else
                    begin
                        left_next  = rd_entry.count;
                        phase_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // Emit one byte per free output slot
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (phase_reg == '0)
                    begin
                        st_next[0] = s0_x;
                        st_next[1] = s1_x;
                        st_next[2] = s2_x ^ t_word;
                        st_next[3] = rotl32(s3_x, ROT_STATE);
                        word_next  = drawn;
                        byte_next  = drawn[BYTE_W-1:0];
                    end
                    else
                    begin
                        word_next = word_reg >> BYTE_W;
                        byte_next = word_reg[2*BYTE_W-1:BYTE_W];
                    end
                    phase_next = phase_reg + 1'b1;
                    left_next  = left_reg - 1'b1;
                    last_next  = (left_reg == COUNT_W'(1));
                    if (left_reg == COUNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            st_reg[0]     <= SEED0;
            st_reg[1]     <= SEED1;
            st_reg[2]     <= SEED2;
            st_reg[3]     <= SEED3;
            left_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            left_reg      <= left_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

FILE: sv/xoshiro128pp_byte_generator_top.sv
// Top level of the xoshiro128++ byte generator: front end, command queue, back end.
// Depends on xpbg_pkg, xpbg_front, xpbg_queue, xpbg_back and the macros header.
//
//   channel | direction | handshake              | payload
//   in      | in        | in_valid / in_stall    | cmd, entropy, byte_count
//   out     | out       | out_valid / out_stall  | rand_byte, last_byte
//
// The back end applies an entropy beat as it pops it; a request of N bytes leaves
// the queue and then streams N bytes, one byte per cycle while out_stall is low,
// paced by the single output register. Empty requests are dropped at the front.
// Reset loads the seed words and empties the queue and output register.
// A stalled output holds the back end; the front keeps taking beats while
// the queue has room.
`include "xoshiro128pp_byte_generator_top_macros.svh"

module xoshiro128pp_byte_generator_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [xpbg_pkg::WORD_W-1:0]   entropy,
    input  logic [xpbg_pkg::COUNT_W-1:0]  byte_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [xpbg_pkg::BYTE_W-1:0]   rand_byte,
    output logic                          last_byte
);
    import xpbg_pkg::*;

    logic          q_push;
    queue_entry_t  q_wr_entry;
    logic          q_wr_ready;
    logic          q_pop;
    queue_entry_t  q_rd_entry;
    logic          q_rd_valid;

    xpbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .entropy    (entropy),
        .byte_count (byte_count),
        .push       (q_push),
        .entry      (q_wr_entry),
        .wr_ready   (q_wr_ready)
    );

    xpbg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .wr_ready (q_wr_ready),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .rd_valid (q_rd_valid)
    );

    xpbg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_entry  (q_rd_entry),
        .rd_valid  (q_rd_valid),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rand_byte (rand_byte),
        .last_byte (last_byte)
    );

    // Entropy beats and non-empty requests must reach the queue side
    `XPBG_ASSERT_NEXT(a_front_keeps, clk, rst_n,
        in_valid && !in_stall && (cmd == CMD_ENTROPY || byte_count != '0), q_push)
    // A taken byte that is not the last is followed straight away by the next
    `XPBG_ASSERT_NEXT(a_burst_gapless, clk, rst_n,
        out_valid && !out_stall && !last_byte, out_valid)
    // The back end pops only a queue that holds an entry
    `XPBG_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, q_rd_valid)

endmodule
